### rtl/cwfb_pkg.sv
// ----------------------------------------------------------------------------
// cwfb_pkg
// Shared types, constants and AES helper functions for the wake frame builder.
// ----------------------------------------------------------------------------
package cwfb_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_SEED     = 2'd0;
  localparam logic [1:0] CFG_COUNTRY_CODE = 2'd1;
  localparam logic [1:0] CFG_DEST_MAC     = 2'd2;
  localparam logic [1:0] CFG_SRC_MAC      = 2'd3;

  // radiotap modes
  localparam logic [1:0] RT_LEGACY = 2'd1;
  localparam logic [1:0] RT_MCS0   = 2'd2;

  localparam int FRAME_BYTES = 80;
  localparam int BODY_BYTES  = 67;
  localparam int CT_BYTES    = 25;
  localparam int MIC_BYTES   = 8;

  localparam logic [15:0] COUNTRY_RESET = 16'h5132;

  typedef struct packed {
    logic [3:0]  key_seed;
    logic [15:0] country_code;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
  } cfg_t;

  // byte 0 in the low bits throughout
  typedef struct packed {
    logic [8*CT_BYTES-1:0]  ct;
    logic [8*MIC_BYTES-1:0] mic;
  } crypt_t;

  typedef struct packed {
    logic [8*FRAME_BYTES-1:0] data;
    logic [3:0]               nwords;
    logic [3:0]               lastcnt;
  } frame_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // MAC register holds the first byte on air in bits 47:40; put it at byte 0
  function automatic logic [47:0] mac_le(input logic [47:0] m);
    logic [47:0] r;
    for (int i = 0; i < 6; i++) begin
      r[8*i +: 8] = m[47-8*i -: 8];
    end
    return r;
  endfunction

  // SubBytes, ShiftRows and (unless last) MixColumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[w+4*c] = SBOX[s[8*(w+4*((c+w)%4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      x  = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        r[32*c      +: 8] = a0 ^ x ^ xt(a0 ^ a1);
        r[32*c + 8  +: 8] = a1 ^ x ^ xt(a1 ^ a2);
        r[32*c + 16 +: 8] = a2 ^ x ^ xt(a2 ^ a3);
        r[32*c + 24 +: 8] = a3 ^ x ^ xt(a3 ^ a0);
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0]  t;
    logic [127:0] n;
    t[7:0]   = SBOX[rk[8*13 +: 8]] ^ rc;
    t[15:8]  = SBOX[rk[8*14 +: 8]];
    t[23:16] = SBOX[rk[8*15 +: 8]];
    t[31:24] = SBOX[rk[8*12 +: 8]];
    n[31:0]   = rk[31:0]   ^ t;
    n[63:32]  = rk[63:32]  ^ n[31:0];
    n[95:64]  = rk[95:64]  ^ n[63:32];
    n[127:96] = rk[127:96] ^ n[95:64];
    return n;
  endfunction

endpackage

### rtl/cwfb_crypt.sv
// ----------------------------------------------------------------------------
// cwfb_crypt
// Iterative AES-128 unit sequencing the CCM blocks: five CBC-MAC blocks then
// three counter blocks, one round per cycle. Rerun after reset and each write.
// ----------------------------------------------------------------------------
module cwfb_crypt
  import cwfb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   restart,
  input  cfg_t   cfg,
  output logic   ready,
  output crypt_t res
);

  typedef enum logic [2:0] {
    CS_KEY  = 3'b001,
    CS_RUN  = 3'b010,
    CS_DONE = 3'b100
  } cstate_t;

  localparam logic [3:0] LAST_RND = 4'd10;
  localparam logic [2:0] BLK_B0   = 3'd0;
  localparam logic [2:0] BLK_A1   = 3'd1;
  localparam logic [2:0] BLK_A2   = 3'd2;
  localparam logic [2:0] BLK_P1   = 3'd3;
  localparam logic [2:0] BLK_P2   = 3'd4;
  localparam logic [2:0] BLK_CTR0 = 3'd5;
  localparam logic [2:0] BLK_CTR1 = 3'd6;
  localparam logic [2:0] BLK_CTR2 = 3'd7;

  cstate_t      state_r, state_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [2:0]   blk_r, blk_nxt;
  logic [127:0] key_r, key_nxt;
  logic [127:0] s_r, s_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic [127:0] cbc_r, cbc_nxt;
  logic [63:0]  mic_r, mic_nxt;
  logic [127:0] ctlo_r, ctlo_nxt;
  logic [71:0]  cthi_r, cthi_nxt;

  logic [47:0]  da, sa;
  logic [127:0] raw, key_w;
  logic [103:0] nonce;
  logic [127:0] blk_b0, blk_a1, blk_a2, blk_p1, blk_in;
  logic [127:0] rk_n, rnd_out;
  logic [7:0]   acc;

  assign da    = mac_le(cfg.dest_mac);
  assign sa    = mac_le(cfg.src_mac);
  assign raw   = {sa, da, 8'h02, cfg.country_code[7:0], cfg.country_code[15:8], 8'h10};
  assign nonce = {8'h01, 40'h0, sa, 8'h07};

  assign blk_b0 = {8'd25, 8'h00, nonce, 8'h59};
  assign blk_a1 = {sa, da, 8'h41, 8'h88, 8'd24, 8'h00};
  assign blk_a2 = {56'h0, 8'h07, 16'h0, da};
  assign blk_p1 = {72'h0, da, 8'h00};

  // key byte i is the seed xored with raw bytes i..15
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      acc = {4'h0, cfg.key_seed};
      for (int j = 0; j < 16; j++) begin
        if (j >= i) acc = acc ^ raw[8*j +: 8];
      end
      key_w[8*i +: 8] = acc;
    end
  end

  always_comb begin
    unique case (blk_r)
      BLK_B0:   blk_in = blk_b0;
      BLK_A1:   blk_in = cbc_r ^ blk_a1;
      BLK_A2:   blk_in = cbc_r ^ blk_a2;
      BLK_P1:   blk_in = cbc_r ^ blk_p1;
      BLK_P2:   blk_in = cbc_r;
      BLK_CTR0: blk_in = {8'd0, 8'h00, nonce, 8'h01};
      BLK_CTR1: blk_in = {8'd1, 8'h00, nonce, 8'h01};
      BLK_CTR2: blk_in = {8'd2, 8'h00, nonce, 8'h01};
      default:  blk_in = blk_b0;
    endcase
  end

  assign rk_n    = key_next(rk_r, rc_r);
  assign rnd_out = aes_round(s_r, rnd_r == LAST_RND) ^ rk_n;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    blk_nxt   = blk_r;
    key_nxt   = key_r;
    s_nxt     = s_r;
    rk_nxt    = rk_r;
    rc_nxt    = rc_r;
    cbc_nxt   = cbc_r;
    mic_nxt   = mic_r;
    ctlo_nxt  = ctlo_r;
    cthi_nxt  = cthi_r;
    unique case (state_r)
      CS_KEY: begin
        key_nxt   = key_w;
        rnd_nxt   = 4'd0;
        blk_nxt   = BLK_B0;
        state_nxt = CS_RUN;
      end
      CS_RUN: begin
        if (rnd_r == 4'd0) begin
          s_nxt   = blk_in ^ key_r;
          rk_nxt  = key_r;
          rc_nxt  = 8'h01;
          rnd_nxt = 4'd1;
        end else begin
          s_nxt  = rnd_out;
          rk_nxt = rk_n;
          rc_nxt = xt(rc_r);
          if (rnd_r == LAST_RND) begin
            rnd_nxt = 4'd0;
            blk_nxt = blk_r + 3'd1;
            priority if (blk_r == BLK_CTR2) begin
              cthi_nxt  = rnd_out[71:0];
              state_nxt = CS_DONE;
            end else if (blk_r == BLK_CTR1) begin
              ctlo_nxt = rnd_out ^ blk_p1;
            end else if (blk_r == BLK_CTR0) begin
              mic_nxt = rnd_out[63:0] ^ cbc_r[63:0];
            end else begin
              cbc_nxt = rnd_out;
            end
          end else begin
            rnd_nxt = rnd_r + 4'd1;
          end
        end
      end
      CS_DONE: begin
      end
      default: state_nxt = CS_KEY;
    endcase
    if (restart) state_nxt = CS_KEY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_KEY;
      rnd_r   <= 4'd0;
      blk_r   <= BLK_B0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      blk_r   <= blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    s_r    <= s_nxt;
    rk_r   <= rk_nxt;
    rc_r   <= rc_nxt;
    cbc_r  <= cbc_nxt;
    mic_r  <= mic_nxt;
    ctlo_r <= ctlo_nxt;
    cthi_r <= cthi_nxt;
  end

  assign ready   = (state_r == CS_DONE);
  assign res.ct  = {cthi_r, ctlo_r};
  assign res.mic = mic_r;

endmodule

### rtl/cwfb_asm.sv
// ----------------------------------------------------------------------------
// cwfb_asm
// Two register stages: item capture, then assembly of the full frame image
// (radiotap, QoS header, CCMP header, ciphertext, MIC).
// ----------------------------------------------------------------------------
module cwfb_asm
  import cwfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [11:0] frm_idx,
  input  logic [1:0]  rtap_sel,
  input  cfg_t        cfg,
  input  crypt_t      crypt,
  output logic        s1_rdy,
  output logic        frm_valid,
  output frame_t      frm,
  input  logic        frm_take
);

  logic        v1_r, v1_nxt;
  logic [11:0] idx_r;
  logic [1:0]  mode_r;
  logic        v2_r, v2_nxt;
  frame_t      frm_r;
  frame_t      frm_nxt;
  logic        s2_ld;

  logic [8*BODY_BYTES-1:0] body;
  logic [15:0]             seq;
  logic [47:0]             da, sa;

  assign s2_ld  = !v2_r || frm_take;
  assign s1_rdy = !v1_r || s2_ld;

  assign da  = mac_le(cfg.dest_mac);
  assign sa  = mac_le(cfg.src_mac);
  assign seq = 16'h02c0 + {4'h0, idx_r[11:4], 4'h0};

  always_comb begin
    body = '0;
    body[7:0]        = 8'h88;
    body[15:8]       = (idx_r[3:0] != 4'h0) ? 8'h49 : 8'h41;   // retry flag
    body[23:16]      = 8'h3c;
    body[8*4  +: 48] = da;
    body[8*10 +: 48] = sa;
    body[8*16 +: 48] = da;
    body[8*22 +: 16] = seq;
    body[8*24 +: 8]  = 8'h07;
    body[8*26 +: 8]  = 8'h01;                                   // PN 1
    body[8*29 +: 8]  = 8'h20;                                   // ext IV
    body[8*34 +: 8*CT_BYTES]  = crypt.ct;
    body[8*59 +: 8*MIC_BYTES] = crypt.mic;
  end

  always_comb begin
    unique case (mode_r)
      RT_LEGACY: begin
        frm_nxt.data    = {8'h00, body, 96'h00_08_00_0c_00_00_80_04_00_0c_00_00};
        frm_nxt.nwords  = 4'd10;
        frm_nxt.lastcnt = 4'd7;
      end
      RT_MCS0: begin
        frm_nxt.data    = {body, 104'h00_00_07_00_08_00_08_80_00_00_0d_00_00};
        frm_nxt.nwords  = 4'd10;
        frm_nxt.lastcnt = 4'd8;
      end
      default: begin
        frm_nxt.data    = {104'h0, body};
        frm_nxt.nwords  = 4'd9;
        frm_nxt.lastcnt = 4'd3;
      end
    endcase
  end

  assign v1_nxt = s1_rdy ? acc : v1_r;
  assign v2_nxt = s2_ld ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && acc) begin
      idx_r  <= frm_idx;
      mode_r <= rtap_sel;
    end
    if (s2_ld && v1_r) begin
      frm_r <= frm_nxt;
    end
  end

  assign frm_valid = v2_r;
  assign frm       = frm_r;

endmodule

### rtl/cwfb_ser.sv
// ----------------------------------------------------------------------------
// cwfb_ser
// Word serialiser: holds one frame image and shifts it out 64 bits at a time
// through a registered output stage.
// ----------------------------------------------------------------------------
module cwfb_ser
  import cwfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        frm_valid,
  input  frame_t      frm,
  output logic        frm_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_frame_word,
  output logic [3:0]  out_byte_count,
  output logic        out_last_word
);

  logic                     act_r, act_nxt;
  logic [8*FRAME_BYTES-1:0] buf_r;
  logic [3:0]               rem_r;
  logic [3:0]               lastcnt_r;
  logic                     ov_r, ov_nxt;
  logic [63:0]              word_r;
  logic [3:0]               cnt_r;
  logic                     last_r;
  logic                     out_ld, emit, is_last;

  assign out_ld   = !ov_r || !out_stall;
  assign emit     = act_r && out_ld;
  assign is_last  = (rem_r == 4'd1);
  assign frm_take = !act_r || (emit && is_last);

  assign act_nxt = frm_take ? frm_valid : act_r;
  assign ov_nxt  = out_ld ? emit : ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word_r <= buf_r[63:0];
      cnt_r  <= is_last ? lastcnt_r : 4'd8;
      last_r <= is_last;
    end
    if (frm_take && frm_valid) begin
      buf_r     <= frm.data;
      rem_r     <= frm.nwords;
      lastcnt_r <= frm.lastcnt;
    end else if (emit) begin
      buf_r <= buf_r >> 64;
      rem_r <= rem_r - 4'd1;
    end
  end

  assign out_valid      = ov_r;
  assign out_frame_word = word_r;
  assign out_byte_count = cnt_r;
  assign out_last_word  = last_r;

endmodule

### rtl/ccmp_wake_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// ccmp_wake_frame_builder_unit
// Builds CCMP-protected 802.11 QoS data wake frames as 64-bit words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one item per frame, carrying the frame
// index and radiotap mode. Output channel (out_valid/out_stall): 9 words for
// a frame without radiotap, 10 with it; the first byte sits in bits 7:0,
// out_byte_count gives the valid bytes and out_last_word closes the frame.
// A taken item passes the capture register, the frame register, the
// serialiser buffer and the output register in turn; items queue in two
// stages ahead of the serialiser while the single 64-bit output port is
// busy. Ciphertext and MIC depend only on the registers, so the AES unit
// runs the eight CCM blocks once, one round per cycle, after reset is
// released and after every register write. in_stall is high throughout.
// Reset clears all in-flight items. When the receiver stalls, the output
// word holds, the pipeline fills and in_stall rises; nothing is lost.
// ----------------------------------------------------------------------------
module ccmp_wake_frame_builder_unit
  import cwfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_frm_idx,
  input  logic [1:0]  in_rtap_sel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_frame_word,
  output logic [3:0]  out_byte_count,
  output logic        out_last_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cfg_t   cfg_r, cfg_nxt;
  crypt_t crypt;
  frame_t frm;
  logic   crypt_rdy, s1_rdy, acc, frm_valid, frm_take;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_SEED:     cfg_nxt.key_seed     = cfg_data[3:0];
        CFG_COUNTRY_CODE: cfg_nxt.country_code = cfg_data[15:0];
        CFG_DEST_MAC:     cfg_nxt.dest_mac     = cfg_data;
        CFG_SRC_MAC:      cfg_nxt.src_mac      = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_seed     <= 4'h0;
      cfg_r.country_code <= COUNTRY_RESET;
      cfg_r.dest_mac     <= 48'h0;
      cfg_r.src_mac      <= 48'h0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = !crypt_rdy || !s1_rdy;
  assign acc      = in_valid && !in_stall;

  cwfb_crypt u_crypt (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .cfg     (cfg_r),
    .ready   (crypt_rdy),
    .res     (crypt)
  );

  cwfb_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .frm_idx   (in_frm_idx),
    .rtap_sel  (in_rtap_sel),
    .cfg       (cfg_r),
    .crypt     (crypt),
    .s1_rdy    (s1_rdy),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_take  (frm_take)
  );

  cwfb_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .frm_valid      (frm_valid),
    .frm            (frm),
    .frm_take       (frm_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_word (out_frame_word),
    .out_byte_count (out_byte_count),
    .out_last_word  (out_last_word)
  );

endmodule

### rtl/cwfb_checker.sv
// ----------------------------------------------------------------------------
// cwfb_checker
// Port-level checks for the wake frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module cwfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_frame_word,
  input logic [3:0]  out_byte_count,
  input logic        out_last_word,
  input logic        cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_word))
    else $error("stalled output item changed");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_word |-> out_byte_count == 4'd8)
    else $error("non-final word not full");

  a_last_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_word |->
      out_byte_count == 4'd3 || out_byte_count == 4'd7 || out_byte_count == 4'd8)
    else $error("bad final word length");

  a_rekey_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input taken while key material is recomputed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ccmp_wake_frame_builder_unit cwfb_checker u_cwfb_checker (.*);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ccmp_wake_frame_builder_unit. A directed table
// and random items run under several register settings. Each accepted item
// is expanded by an in-bench CCMP frame model into the expected words, and
// every output word is compared field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cwfb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] in_frm_idx;
  logic [1:0]  in_rtap_sel;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_frame_word;
  logic [3:0]  out_byte_count;
  logic        out_last_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;

  ccmp_wake_frame_builder_unit dut (.*);

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
  } frame_word_t;

  typedef struct packed {
    logic [11:0] idx;
    logic [1:0]  mode;
    logic [3:0]  last_cnt;
  } directed_row_t;

  localparam logic [1:0] RT_NONE   = 2'd0;
  localparam logic [1:0] RT_UNUSED = 2'd3;

  // index, radiotap mode, byte count of the closing word
  localparam directed_row_t DIRECTED [13] = '{
    '{12'h000, RT_NONE,   4'd3}, '{12'h000, RT_LEGACY, 4'd7}, '{12'h000, RT_MCS0, 4'd8},
    '{12'h000, RT_UNUSED, 4'd3}, '{12'hfff, RT_NONE,   4'd3}, '{12'hfff, RT_LEGACY, 4'd7},
    '{12'hfff, RT_MCS0,   4'd8}, '{12'h010, RT_NONE,   4'd3}, '{12'h001, RT_NONE,   4'd3},
    '{12'h00f, RT_MCS0,   4'd8}, '{12'h800, RT_LEGACY, 4'd7}, '{12'haaa, RT_UNUSED, 4'd3},
    '{12'h555, RT_MCS0,   4'd8}
  };

  frame_word_t pending_words [$];
  int unsigned errors;
  int unsigned cycles = 0;
  int unsigned burst_left;
  int unsigned stall_kind = 0;

  // model copy of the registers
  logic [3:0]  m_seed;
  logic [15:0] m_country;
  logic [47:0] m_dmac;
  logic [47:0] m_smac;
  logic [7:0]  round_key [176];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
    $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
    errors++;
  endtask

  function automatic logic [7:0] dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void load_key(input logic [127:0] k);
    logic [7:0] t [4];
    logic [7:0] rc;
    logic [7:0] f;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) round_key[i] = k[8*i +: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = round_key[4*(i-1)+j];
      if (i % 4 == 0) begin
        f    = t[0];
        t[0] = SBOX[t[1]] ^ rc;
        t[1] = SBOX[t[2]];
        t[2] = SBOX[t[3]];
        t[3] = SBOX[f];
        rc   = dbl(rc);
      end
      for (int j = 0; j < 4; j++) round_key[4*i+j] = round_key[4*(i-4)+j] ^ t[j];
    end
  endfunction

  // byte i of a block lives in bits 8*i+7..8*i
  function automatic logic [127:0] encrypt(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8] ^ round_key[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) t[w+4*c] = SBOX[s[w+4*((c+w)%4)]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          x  = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_key[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  // works out the words of one wake frame and queues them; returns the
  // byte count of the closing word
  function automatic logic [3:0] queue_wake_frame(input logic [11:0] idx, input logic [1:0] mode);
    logic [7:0]   da [6];
    logic [7:0]   sa [6];
    logic [7:0]   raw [16];
    logic [7:0]   hdr [26];
    logic [7:0]   fr [80];
    logic [127:0] key, b0, a_lo, a_hi, p_lo, p_hi, mac, ctr, s0, s1, s2, ctb;
    logic [255:0] aadblk, ptblk;
    logic [7:0]   prev;
    logic [15:0]  fc, seq, m;
    logic [103:0] nonce;
    int           rt, n, nw, cnt;
    frame_word_t  fw;
    for (int i = 0; i < 6; i++) begin
      da[i] = m_dmac[47-8*i -: 8];
      sa[i] = m_smac[47-8*i -: 8];
    end
    raw[0] = 8'd16; raw[1] = m_country[15:8]; raw[2] = m_country[7:0]; raw[3] = 8'd2;
    for (int i = 0; i < 6; i++) begin
      raw[4+i]  = da[i];
      raw[10+i] = sa[i];
    end
    prev = {4'h0, m_seed};
    for (int i = 15; i >= 0; i--) begin
      prev = prev ^ raw[i];
      key[8*i +: 8] = prev;
    end
    load_key(key);

    seq = 16'h02c0 + {4'h0, idx[11:4], 4'h0};
    fc  = 16'h4188 | ((idx[3:0] != 4'h0) ? 16'h0800 : 16'h0000);
    hdr[0] = fc[7:0]; hdr[1] = fc[15:8]; hdr[2] = 8'h3c; hdr[3] = 8'h00;
    for (int i = 0; i < 6; i++) begin
      hdr[4+i]  = da[i];
      hdr[10+i] = sa[i];
      hdr[16+i] = da[i];
    end
    hdr[22] = seq[7:0]; hdr[23] = seq[15:8]; hdr[24] = 8'h07; hdr[25] = 8'h00;

    // masked frame control: subtype bits 4-6, retry, power, more-data and order cleared, protected set
    m = fc & ~16'h3800 & ~16'h0070 & ~16'h8000 | 16'h4000;
    aadblk = '0;
    aadblk[15:8] = 8'd24;
    aadblk[23:16] = m[7:0];
    aadblk[31:24] = m[15:8];
    for (int i = 0; i < 18; i++) aadblk[8*(4+i) +: 8] = hdr[4+i];
    aadblk[8*22 +: 8] = {4'h0, seq[3:0]};
    aadblk[8*24 +: 8] = 8'h07;

    nonce = '0;
    nonce[7:0] = 8'h07;
    for (int i = 0; i < 6; i++) nonce[8*(1+i) +: 8] = sa[i];
    nonce[8*12 +: 8] = 8'h01;

    ptblk = '0;
    for (int i = 0; i < 6; i++) ptblk[8*(1+i) +: 8] = da[i];

    b0 = {8'd25, 8'h00, nonce, 8'h59};
    a_lo = aadblk[127:0];  a_hi = aadblk[255:128];
    p_lo = ptblk[127:0];   p_hi = ptblk[255:128];
    mac = encrypt(b0);
    mac = encrypt(mac ^ a_lo);
    mac = encrypt(mac ^ a_hi);
    mac = encrypt(mac ^ p_lo);
    mac = encrypt(mac ^ p_hi);
    ctr = {8'd0, 8'h00, nonce, 8'h01};
    s0 = encrypt(ctr);
    ctr[127:120] = 8'd1;
    s1 = encrypt(ctr);
    ctr[127:120] = 8'd2;
    s2 = encrypt(ctr);

    for (int i = 0; i < 80; i++) fr[i] = 8'h00;
    rt = (mode == RT_LEGACY) ? 12 : (mode == RT_MCS0) ? 13 : 0;
    if (mode == RT_LEGACY) begin
      fr[2] = 8'd12; fr[4] = 8'h04; fr[5] = 8'h80; fr[8] = 8'd12; fr[10] = 8'h08;
    end else if (mode == RT_MCS0) begin
      fr[2] = 8'd13; fr[5] = 8'h80; fr[6] = 8'h08; fr[8] = 8'h08; fr[10] = 8'h07;
    end
    n = rt;
    for (int i = 0; i < 26; i++) fr[n+i] = hdr[i];
    n += 26;
    fr[n] = 8'h01;
    fr[n+3] = 8'h20;
    n += 8;
    for (int i = 0; i < 25; i++) begin
      ctb = (i < 16) ? (p_lo ^ s1) : (p_hi ^ s2);
      fr[n+i] = ctb[8*(i%16) +: 8];
    end
    n += 25;
    for (int i = 0; i < 8; i++) fr[n+i] = mac[8*i +: 8] ^ s0[8*i +: 8];
    n += 8;

    nw = (n + 7) / 8;
    for (int w = 0; w < nw; w++) begin
      cnt = n - 8*w;
      if (cnt > 8) cnt = 8;
      fw.word = '0;
      for (int b = 0; b < cnt; b++) fw.word[8*b +: 8] = fr[8*w+b];
      fw.cnt  = cnt[3:0];
      fw.last = (w + 1 == nw);
      pending_words.push_back(fw);
    end
    return cnt[3:0];
  endfunction

  task automatic send_item(input logic [11:0] idx, input logic [1:0] mode,
                           output logic [3:0] last_cnt);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid    <= 1'b1;
    in_frm_idx  <= idx;
    in_rtap_sel <= mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_cnt = queue_wake_frame(idx, mode);
    burst_left--;
  endtask

  // sender holds off until every queued word has left, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [47:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    case (index)
      CFG_KEY_SEED:     m_seed    = data[3:0];
      CFG_COUNTRY_CODE: m_country = data[15:0];
      CFG_DEST_MAC:     m_dmac    = data;
      CFG_SRC_MAC:      m_smac    = data;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [47:0] seed, input logic [47:0] cc,
                           input logic [47:0] dmac, input logic [47:0] smac);
    cfg_write(CFG_KEY_SEED, seed);
    cfg_write(CFG_COUNTRY_CODE, cc);
    cfg_write(CFG_DEST_MAC, dmac);
    cfg_write(CFG_SRC_MAC, smac);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(input int count);
    logic [11:0] idx;
    logic [3:0]  lc;
    for (int k = 0; k < count; k++) begin
      idx = 12'($urandom());
      if ($urandom_range(0, 3) == 0) idx[3:0] = 4'h0;
      send_item(idx, 2'($urandom_range(0, 3)), lc);
    end
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // receiver: the stall style is redrawn at random, at regular intervals
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) stall_kind <= $urandom_range(0, 3);
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= (cycles % 7) < 3;
      default: out_stall <= (cycles % 64) < 40;
    endcase
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    frame_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", 64'd0, out_frame_word);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_frame_word !== exp_w.word) report("frame_word", exp_w.word, out_frame_word);
        if (out_byte_count !== exp_w.cnt)
          report("byte_count", 64'(exp_w.cnt), 64'(out_byte_count));
        if (out_last_word !== exp_w.last)
          report("last_word", 64'(exp_w.last), 64'(out_last_word));
      end
    end
  end

  initial begin
    logic [3:0] lc;
    errors     = 0;
    burst_left = 0;
    m_seed     = 4'h0;
    m_country  = COUNTRY_RESET;
    m_dmac     = '0;
    m_smac     = '0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_frm_idx  <= '0;
    in_rtap_sel <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset register values
    foreach (DIRECTED[r]) begin
      send_item(DIRECTED[r].idx, DIRECTED[r].mode, lc);
      if (lc !== DIRECTED[r].last_cnt)
        report("closing byte count", 64'(DIRECTED[r].last_cnt), 64'(lc));
    end
    drain();

    write_all(48'd0, 48'd0, 48'd0, 48'd0);
    random_items(40);
    drain();
    // over-wide values: only the register width is kept
    write_all(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff);
    random_items(40);
    for (int p = 0; p < 4; p++) begin
      drain();
      write_all(rand48(), rand48(), rand48(), rand48());
      random_items(35);
    end
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
